// ----- src/psp_pkg.sv -----
`default_nettype none

package psp_pkg;

  localparam int CHAR_BITS    = 8;
  localparam int MAX_PREAMBLE = 16;
  localparam int MAX_MESSAGE  = 255;

  localparam int PRE_LEN_BITS = 5;
  localparam int MSG_LEN_BITS = 8;
  localparam int FILL_BITS    = 4;
  localparam int CHARS_BITS   = MAX_PREAMBLE * CHAR_BITS;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_DATA_BITS-1:0] PRE_LOW_RESET  = 64'd6071228645619286339;
  localparam logic [CFG_DATA_BITS-1:0] PRE_HIGH_RESET = 64'd5132105;
  localparam logic [PRE_LEN_BITS-1:0]  PRE_LEN_RESET  = 5'd11;
  localparam logic [MSG_LEN_BITS-1:0]  MSG_LEN_RESET  = 8'd100;

  // Fill count that marks a complete character in the window.
  localparam logic [FILL_BITS-1:0] FILL_FULL  = 4'd8;
  // After a mismatch the window slides one bit: seven bits stay fresh.
  localparam logic [FILL_BITS-1:0] FILL_SLIDE = 4'd7;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PRE_LOW  = 2'd0,
    CFG_PRE_HIGH = 2'd1,
    CFG_PRE_LEN  = 2'd2,
    CFG_MSG_LEN  = 2'd3
  } cfg_reg_t;

  // Effective configuration seen by the detector.
  typedef struct packed {
    logic [CHARS_BITS-1:0]   chars;
    logic [PRE_LEN_BITS-1:0] pre_len;
    logic [MSG_LEN_BITS-1:0] msg_len;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0]    payload_byte;
    logic [MSG_LEN_BITS-1:0] byte_index;
    logic                    last_byte;
  } result_t;

endpackage

`default_nettype wire

// ----- src/psp_cfg.sv -----
`default_nettype none

module psp_cfg
  import psp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  logic [CFG_DATA_BITS-1:0] pre_low;
  logic [CFG_DATA_BITS-1:0] pre_high;
  logic [PRE_LEN_BITS-1:0]  pre_len;
  logic [MSG_LEN_BITS-1:0]  msg_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_low  <= PRE_LOW_RESET;
      pre_high <= PRE_HIGH_RESET;
      pre_len  <= PRE_LEN_RESET;
      msg_len  <= MSG_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PRE_LOW:  pre_low  <= cfg_data;
        CFG_PRE_HIGH: pre_high <= cfg_data;
        CFG_PRE_LEN:  pre_len  <= cfg_data[PRE_LEN_BITS-1:0];
        CFG_MSG_LEN:  msg_len  <= cfg_data[MSG_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Zero lengths act as one; preamble length saturates at the table size.
  always_comb begin
    cfg.chars = {pre_high, pre_low};
    if (pre_len == '0) begin
      cfg.pre_len = PRE_LEN_BITS'(1);
    end else if (pre_len > PRE_LEN_BITS'(MAX_PREAMBLE)) begin
      cfg.pre_len = PRE_LEN_BITS'(MAX_PREAMBLE);
    end else begin
      cfg.pre_len = pre_len;
    end
    cfg.msg_len = (msg_len == '0) ? MSG_LEN_BITS'(1) : msg_len;
  end

endmodule

`default_nettype wire

// ----- src/psp_core.sv -----
`default_nettype none

module psp_core
  import psp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic step,
  input  wire logic bit_in,
  output logic      res_valid,
  output result_t   res
);

  logic [CHAR_BITS-1:0]    bit_window;
  logic [FILL_BITS-1:0]    fill_count;
  logic [PRE_LEN_BITS-1:0] match_index;
  logic                    capturing;
  logic [MSG_LEN_BITS-1:0] payload_count;

  logic [CHAR_BITS-1:0]    bit_window_next;
  logic [FILL_BITS-1:0]    fill_count_next;
  logic [PRE_LEN_BITS-1:0] match_index_next;
  logic                    capturing_next;
  logic [MSG_LEN_BITS-1:0] payload_count_next;

  logic [FILL_BITS-1:0]    fill_inc;
  logic [CHAR_BITS-1:0]    expect_char;
  logic [PRE_LEN_BITS-1:0] match_inc;
  logic                    last;

  always_comb begin
    bit_window_next    = {bit_in, bit_window[CHAR_BITS-1:1]};
    fill_inc           = (fill_count < FILL_FULL) ? fill_count + FILL_BITS'(1) : fill_count;
    expect_char        = cfg.chars[{match_index[3:0], 3'b000} +: CHAR_BITS];
    match_inc          = match_index + PRE_LEN_BITS'(1);
    last               = ({1'b0, payload_count} + 9'd1) >= {1'b0, cfg.msg_len};

    fill_count_next    = fill_inc;
    match_index_next   = match_index;
    capturing_next     = capturing;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res.payload_byte   = bit_window_next;
    res.byte_index     = payload_count;
    res.last_byte      = last;

    if (fill_inc == FILL_FULL) begin
      if (capturing) begin
        res_valid       = 1'b1;
        fill_count_next = '0;
        if (last) begin
          payload_count_next = '0;
          capturing_next     = 1'b0;
          match_index_next   = '0;
        end else begin
          payload_count_next = payload_count + MSG_LEN_BITS'(1);
        end
      end else if (bit_window_next == expect_char) begin
        match_index_next = match_inc;
        fill_count_next  = '0;
        if (match_inc >= cfg.pre_len) begin
          capturing_next     = 1'b1;
          payload_count_next = '0;
        end
      end else begin
        match_index_next = '0;
        fill_count_next  = FILL_SLIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_window    <= '0;
      fill_count    <= '0;
      match_index   <= '0;
      capturing     <= 1'b0;
      payload_count <= '0;
    end else if (step) begin
      bit_window    <= bit_window_next;
      fill_count    <= fill_count_next;
      match_index   <= match_index_next;
      capturing     <= capturing_next;
      payload_count <= payload_count_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_FULL)
    else $error("fill count past a full character");

  a_capture_needs_match: assert property (@(posedge clk) disable iff (rst)
    capturing |-> match_index != '0)
    else $error("capturing without a matched preamble");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.last_byte |=> !capturing && payload_count == '0)
    else $error("frame did not end after last byte");

  a_result_only_capturing: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> capturing)
    else $error("result while searching");
`endif

endmodule

`default_nettype wire

// ----- src/preamble_sync_payload_capture.sv -----
// Latency: a stream bit accepted at one edge is processed at the next edge at which the
//   result register is empty or drained; its byte, if any, is on the outputs from that edge.
// Throughput: one bit per cycle; while a byte waits under out_stall and the input register
//   is full, in_stall follows out_stall in the same cycle.
// Reset (rst, synchronous): clears search/capture state and both pipeline valids,
//   and loads the configuration registers with their default preamble and lengths.
`default_nettype none

module preamble_sync_payload_capture
  import psp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration write port
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  // bit stream in
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      stream_bit,
  // payload bytes out
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [CHAR_BITS-1:0]           payload_byte,
  output logic [MSG_LEN_BITS-1:0]        byte_index,
  output logic                           last_byte
);

  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  // Input register: one buffered stream bit.
  logic    s1_valid;
  logic    s1_bit;
  logic    in_beat;
  // The buffered bit moves through the detector when the result register
  // is empty or is being drained this cycle.
  logic    step;

  assign step     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !step;
  assign in_beat  = in_valid && !in_stall;

  psp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .bit_in    (s1_bit),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_bit <= stream_bit;
    end
  end

  // Result register. Bits that complete no payload byte leave it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      payload_byte <= res.payload_byte;
      byte_index   <= res.byte_index;
      last_byte    <= res.last_byte;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(byte_index))
    else $error("stalled result lost or changed");

  a_step_needs_room: assert property (@(posedge clk) disable iff (rst)
    step |-> !(out_valid && out_stall))
    else $error("bit processed into an occupied result register");
`endif

endmodule

`default_nettype wire

// ----- test/tb_preamble_sync_payload_capture.sv -----
`timescale 1ns / 100ps

module tb_preamble_sync_payload_capture;
  import psp_pkg::*;

  // Sequence-length markers used by the stimulus tasks.
  localparam int WHOLE = -1;          // send the full preamble / a full message
  localparam int SETTLE_CYCLES = 4;   // pipeline drain before touching registers
  localparam int LONG_HOLD = 120;     // output hold-off long enough to back up the input
  localparam int MAX_NOTES = 20;      // mismatch lines printed before going quiet
  localparam int RANDOM_BITS = 120;   // stream beats in the random part
  localparam int RANDOM_BYTES = 12;   // payload bytes the random part should yield
  localparam int CALM_AFTER = 90;     // random beats after which idling stops

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIX_LO = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] MIX_HI = 64'hFEDC_BA98_7654_3210;
  // char 0 = A5, char 1 = C3: a doubled first char exercises the no-retest rule
  localparam logic [63:0] ECHO_LO = 64'h0000_0000_0000_C3A5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic stream_bit = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAR_BITS-1:0] payload_byte;
  logic [MSG_LEN_BITS-1:0] byte_index;
  logic last_byte;

  always #4 clk = ~clk;

  preamble_sync_payload_capture dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stream_bit(stream_bit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .payload_byte(payload_byte),
    .byte_index(byte_index),
    .last_byte(last_byte)
  );

  // ---------------------------------------------------------------------------
  // Frame tracker: shadow registers plus the search/capture state, advanced
  // once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [63:0] pre_lo_q, pre_hi_q;
  logic [PRE_LEN_BITS-1:0] pre_len_q;
  logic [MSG_LEN_BITS-1:0] msg_len_q;

  logic [CHAR_BITS-1:0] win;        // last 8 stream bits, newest at bit 7
  logic [FILL_BITS-1:0] fresh;      // bits shifted in since the last advance
  logic [PRE_LEN_BITS-1:0] matched; // preamble chars matched so far
  logic in_payload;
  logic [MSG_LEN_BITS-1:0] sent;    // payload bytes emitted in this frame

  result_t pending_bytes[$];        // payload bytes still owed by the block

  // A directed row may pin its first payload byte to a hand-written value.
  logic typed_armed = 1'b0;
  result_t typed_want;

  int errors = 0;
  int bits_taken = 0;
  int bytes_checked = 0;
  int settings_used = 0;

  // Idling knobs; 0 means no idling on that side.
  int tx_odds = 6;
  int rx_odds = 5;
  int holds_asked = 0;
  int holds_served = 0;
  int unsigned hold_left = 0;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_NOTES) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Out-of-range lengths clamp: zero acts as one, anything past the max saturates.
  function automatic int preamble_span();
    int n;
    n = pre_len_q;
    if (n == 0) n = 1;
    if (n > MAX_PREAMBLE) n = MAX_PREAMBLE;
    return n;
  endfunction

  function automatic int message_span();
    int n;
    n = msg_len_q;
    if (n == 0) n = 1;
    if (n > MAX_MESSAGE) n = MAX_MESSAGE;
    return n;
  endfunction

  // Preamble char k; index wraps at 16, chars 8..15 live in the high word.
  function automatic logic [CHAR_BITS-1:0] sync_char(input logic [PRE_LEN_BITS-1:0] k);
    logic [63:0] word;
    word = k[3] ? pre_hi_q : pre_lo_q;
    return word[{k[2:0], 3'b000} +: CHAR_BITS];
  endfunction

  task automatic clear_tracker();
    pre_lo_q = PRE_LOW_RESET;
    pre_hi_q = PRE_HIGH_RESET;
    pre_len_q = PRE_LEN_RESET;
    msg_len_q = MSG_LEN_RESET;
    win = '0;
    fresh = '0;
    matched = '0;
    in_payload = 1'b0;
    sent = '0;
    pending_bytes.delete();
  endtask

  task automatic apply_write(input cfg_reg_t idx, input logic [63:0] data);
    case (idx)
      CFG_PRE_LOW: pre_lo_q = data;
      CFG_PRE_HIGH: pre_hi_q = data;
      CFG_PRE_LEN: pre_len_q = data[PRE_LEN_BITS-1:0];
      CFG_MSG_LEN: msg_len_q = data[MSG_LEN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic track_bit(input logic b);
    result_t r;
    logic last;
    win = {b, win[CHAR_BITS-1:1]};
    if (fresh < FILL_FULL) fresh++;
    // Nothing to test until a whole character has shifted in.
    if (fresh == FILL_FULL) begin
      if (in_payload) begin
        last = (int'(sent) + 1 >= message_span());
        r.payload_byte = win;
        r.byte_index = sent;
        r.last_byte = last;
        if (typed_armed) begin
          r = typed_want;
          typed_armed = 1'b0;
        end
        pending_bytes.push_back(r);
        fresh = '0;
        if (last) begin
          sent = '0;
          in_payload = 1'b0;
          matched = '0;
        end else begin
          sent++;
        end
      end else if (win == sync_char(matched)) begin
        matched++;
        fresh = '0;
        // ">=" so a length cut below the progress ends the search at once
        if (int'(matched) >= preamble_span()) begin
          in_payload = 1'b1;
          sent = '0;
        end
      end else begin
        // slide one bit; the rejected window is not retried as char 0
        matched = '0;
        fresh = FILL_SLIDE;
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_bytes.size() == 0) begin
      note_error($sformatf("payload byte %02h idx %0d with none expected",
                           payload_byte, byte_index));
    end else begin
      want = pending_bytes.pop_front();
      if (payload_byte !== want.payload_byte)
        note_error($sformatf("payload_byte %02h, expected %02h (idx %0d)",
                             payload_byte, want.payload_byte, want.byte_index));
      if (byte_index !== want.byte_index)
        note_error($sformatf("byte_index %0d, expected %0d", byte_index, want.byte_index));
      if (last_byte !== want.last_byte)
        note_error($sformatf("last_byte %0b, expected %0b (idx %0d)",
                             last_byte, want.last_byte, want.byte_index));
      bytes_checked++;
    end
  endtask

  // Monitor: everything sampled at the edge, before any update of this step.
  // Output is checked before the new beat is tracked so a same-edge prediction
  // can never pair up with an older output.
  always @(posedge clk) begin
    if (rst) begin
      clear_tracker();
    end else begin
      if (cfg_write) apply_write(cfg_reg_t'(cfg_index), cfg_data);
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        track_bit(stream_bit);
        bits_taken++;
      end
    end
  end

  // Receiver: short random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One stream beat; may open with an idle gap. Returns at the accepting edge.
  task automatic push_bit(input logic b);
    if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_bit <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Characters go out first bit as LSB.
  task automatic push_byte(input logic [CHAR_BITS-1:0] c);
    int i;
    for (i = 0; i < CHAR_BITS; i++) push_bit(c[i]);
  endtask

  // Preamble chars pre_from.. then payload; flip corrupts one preamble bit.
  task automatic send_frame(input int pre_from, input int pre_n, input int pay_n,
                            input bit scramble, input logic [7:0] body, input int flip);
    int k;
    int cnt;
    logic [CHAR_BITS-1:0] c;
    cnt = (pre_n == WHOLE) ? preamble_span() - pre_from : pre_n;
    for (k = 0; k < cnt; k++) begin
      c = sync_char(PRE_LEN_BITS'(pre_from + k));
      if (flip >= 0 && k == flip / 8) c[flip % 8] = ~c[flip % 8];
      push_byte(c);
    end
    cnt = (pay_n == WHOLE) ? message_span() : pay_n;
    for (k = 0; k < cnt; k++) push_byte(scramble ? 8'($urandom) : body + 8'(k));
  endtask

  // Stop feeding and let everything owed come out, then let the pipe empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Length registers get junk above their width; only the low bits count.
  task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [PRE_LEN_BITS-1:0] plen,
                               input logic [MSG_LEN_BITS-1:0] mlen);
    logic [63:0] junk;
    write_reg(CFG_PRE_LOW, lo);
    write_reg(CFG_PRE_HIGH, hi);
    junk = {$urandom, $urandom};
    write_reg(CFG_PRE_LEN, {junk[63:PRE_LEN_BITS], plen});
    junk = {$urandom, $urandom};
    write_reg(CFG_MSG_LEN, {junk[63:MSG_LEN_BITS], mlen});
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Each row optionally reloads the registers, sends lead
  // bytes, part or all of the preamble, then payload counting up from body.
  // Typed rows start from a clean search state and pin their first byte.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit program_it;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [PRE_LEN_BITS-1:0] plen;
    logic [MSG_LEN_BITS-1:0] mlen;
    logic [7:0] lead;
    int lead_n;
    int pre_from;
    int pre_n;
    int pay_n;
    logic [7:0] body;
    bit typed;
    logic [7:0] t_byte;
    bit t_last;
  } drill_t;

  drill_t drills [0:9] = '{
    // settings out of reset: 11-char preamble, 100-byte message; stop four bytes in ...
    '{1'b0, 64'd0, 64'd0, 5'd0, 8'd0, 8'h00, 0, 0, WHOLE, 4, 8'h3C, 1'b1, 8'h3C, 1'b0},
    // ... then cut the message length below that: the next byte is the last
    '{1'b1, PRE_LOW_RESET, PRE_HIGH_RESET, 5'd11, 8'd3, 8'h00, 0, 0, 0, 1, 8'h20,
      1'b0, 8'h00, 1'b0},
    // zero lengths act as one; all-ones chars
    '{1'b1, ALL_ONES, ALL_ONES, 5'd0, 8'd0, 8'h00, 0, 0, WHOLE, WHOLE, 8'hFF,
      1'b1, 8'hFF, 1'b1},
    // all-zero chars, preamble length saturates at 16, longest message; two bytes in ...
    '{1'b1, 64'd0, 64'd0, 5'd31, 8'd255, 8'h00, 0, 0, WHOLE, 2, 8'h80,
      1'b1, 8'h80, 1'b0},
    // ... then a cut to two ends the frame with the third byte
    '{1'b1, MIX_LO, MIX_HI, 5'd16, 8'd2, 8'h00, 0, 0, 0, 1, 8'h90, 1'b0, 8'h00, 1'b0},
    '{1'b1, MIX_LO, MIX_HI, 5'd16, 8'd1, 8'h00, 0, 0, WHOLE, WHOLE, 8'h5A, 1'b1, 8'h5A, 1'b1},
    '{1'b1, MIX_LO, MIX_HI, 5'd17, 8'd2, 8'h00, 0, 0, WHOLE, WHOLE, 8'h01, 1'b1, 8'h01, 1'b0},
    // six chars into a 16-char preamble ...
    '{1'b1, MIX_LO, MIX_HI, 5'd16, 8'd4, 8'h00, 0, 0, 6, 0, 8'h00, 1'b0, 8'h00, 1'b0},
    // ... then shrink it to 3: the seventh match starts capture
    '{1'b1, MIX_LO, MIX_HI, 5'd3, 8'd4, 8'h00, 0, 6, 1, WHOLE, 8'h30, 1'b0, 8'h00, 1'b0},
    // doubled first char: the second copy fails as char 1 and is not retried
    '{1'b1, ECHO_LO, ALL_ONES, 5'd2, 8'd3, 8'hA5, 1, 0, WHOLE, WHOLE, 8'h40,
      1'b0, 8'h00, 1'b0}
  };

  // One random phase: fresh settings, then a few frames. Mostly clean
  // frames with random payload, some noise, corrupted and truncated preambles.
  // A squeeze phase runs the sender flat out under the long output hold-off.
  task automatic random_phase(input bit calm, input bit squeeze);
    logic [PRE_LEN_BITS-1:0] plen;
    logic [MSG_LEN_BITS-1:0] mlen;
    int frames;
    int kind;
    settle();
    if ($urandom_range(0, 7) == 0) plen = PRE_LEN_BITS'($urandom_range(16, 31));
    else plen = PRE_LEN_BITS'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) mlen = MSG_LEN_BITS'($urandom_range(20, 40));
    else mlen = MSG_LEN_BITS'($urandom_range(0, 8));
    if (squeeze) begin
      plen = PRE_LEN_BITS'($urandom_range(1, 2));
      mlen = 8'd4;
    end
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, plen, mlen);
    tx_odds = (calm || squeeze || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
    rx_odds = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
    if (squeeze) holds_asked++;
    frames = $urandom_range(1, 3);
    repeat (frames) begin
      kind = squeeze ? 0 : $urandom_range(0, 9);
      if (kind <= 6) begin
        send_frame(0, WHOLE, WHOLE, 1'b1, 8'h00, -1);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 24)) push_bit(1'($urandom));
      end else if (kind == 8) begin
        send_frame(0, WHOLE, $urandom_range(0, 3), 1'b1, 8'h00,
                   $urandom_range(0, 8 * preamble_span() - 1));
      end else begin
        send_frame(0, $urandom_range(0, preamble_span() - 1), $urandom_range(0, 3),
                   1'b1, 8'h00, -1);
      end
    end
  endtask

  initial begin
    int bits0;
    int bytes0;
    int phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (drills[i]) begin
      settle();
      if (drills[i].program_it)
        load_settings(drills[i].lo, drills[i].hi, drills[i].plen, drills[i].mlen);
      typed_want.payload_byte = drills[i].t_byte;
      typed_want.byte_index = '0;
      typed_want.last_byte = drills[i].t_last;
      typed_armed = drills[i].typed;
      repeat (drills[i].lead_n) push_byte(drills[i].lead);
      send_frame(drills[i].pre_from, drills[i].pre_n, drills[i].pay_n, 1'b0,
                 drills[i].body, -1);
    end

    // Random part; the first phase is the squeeze, the tail runs without idling.
    bits0 = bits_taken;
    bytes0 = bytes_checked;
    phase = 0;
    while (bits_taken - bits0 < RANDOM_BITS || bytes_checked - bytes0 < RANDOM_BYTES) begin
      random_phase(bits_taken - bits0 >= CALM_AFTER, phase == 0);
      phase++;
    end
    random_phase(1'b1, 1'b0);

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0)
      note_error($sformatf("%0d payload bytes never came out", pending_bytes.size()));

    $display("Run fed %0d stream beats and checked %0d payload bytes over %0d settings,",
             bits_taken, bytes_checked, settings_used);
    $display("with length cuts mid-frame and a %0d-cycle output hold-off.", LONG_HOLD);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
